// File: src/zero_cross_lock_and_mains_freq_macros.svh
// Assertion helpers for the zero-cross lock block.
`ifndef ZERO_CROSS_LOCK_AND_MAINS_FREQ_MACROS_SVH
`define ZERO_CROSS_LOCK_AND_MAINS_FREQ_MACROS_SVH

// cons must hold in the same cycle as cond
`define ZCLM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("%m: assertion failed");

// cons must hold in the cycle after cond
`define ZCLM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("%m: assertion failed");

// first, then second in the cycle after it, then cons in the cycle after that
`define ZCLM_ASSERT_SEQ(label, clk, rst_n, first, second, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (first) ##1 (second) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: src/zclm_pkg.sv
`timescale 1ns / 1ps

package zclm_pkg;

    // APB address width: six registers on a 4-byte stride
    localparam int unsigned AddrW = 5;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_MIN_DETECT = 3'd0;
    localparam logic [2:0] REG_WINDOW_MS  = 3'd1;
    localparam logic [2:0] REG_B50_LOW    = 3'd2;
    localparam logic [2:0] REG_B50_HIGH   = 3'd3;
    localparam logic [2:0] REG_B60_LOW    = 3'd4;
    localparam logic [2:0] REG_B60_HIGH   = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_MIN_DETECT = 8'd10;
    localparam logic [15:0] RST_WINDOW_MS  = 16'd1000;
    localparam logic [15:0] RST_B50_LOW    = 16'd190;
    localparam logic [15:0] RST_B50_HIGH   = 16'd210;
    localparam logic [15:0] RST_B60_LOW    = 16'd215;
    localparam logic [15:0] RST_B60_HIGH   = 16'd235;

    // Item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Classified frequencies and fault limit
    localparam logic [5:0] FREQ_NONE   = 6'd0;
    localparam logic [5:0] FREQ_A_HZ   = 6'd50;
    localparam logic [5:0] FREQ_B_HZ   = 6'd60;
    localparam logic [1:0] FAULT_LIMIT = 2'd2;

    typedef struct packed {
        logic [7:0]  min_detect_cycles;
        logic [15:0] window_ms;
        logic [15:0] band50_low;
        logic [15:0] band50_high;
        logic [15:0] band60_low;
        logic [15:0] band60_high;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [15:0] period_ms;
    } t_item;

    typedef struct packed {
        logic        locked;
        logic [5:0]  freq_hz;
    } t_result;

endpackage

// File: src/zclm_core.sv
`timescale 1ns / 1ps

module zclm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  zclm_pkg::t_item   i_item,
    input  zclm_pkg::t_cfg    i_cfg,
    output zclm_pkg::t_result o_result
);

    logic [8:0]  r_warmup,   n_warmup;
    logic        r_lock,     n_lock;
    logic [15:0] r_led,      n_led;
    logic [15:0] r_tick,     n_tick;
    logic [1:0]  r_fault,    n_fault;
    logic [15:0] r_wec,      n_wec;
    logic [16:0] r_elapsed,  n_elapsed;
    logic [5:0]  r_freq,     n_freq;

    logic [15:0] w_tick_inc;
    logic [1:0]  w_fault_inc;
    logic [17:0] w_el_sum;
    logic [16:0] w_el_sat;

    always_comb begin
        n_warmup  = r_warmup;
        n_lock    = r_lock;
        n_led     = r_led;
        n_tick    = r_tick;
        n_fault   = r_fault;
        n_wec     = r_wec;
        n_elapsed = r_elapsed;
        n_freq    = r_freq;

        w_tick_inc  = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;
        w_fault_inc = (r_fault == 2'd3) ? r_fault : r_fault + 2'd1;
        w_el_sum    = {1'b0, r_elapsed} + {2'b00, i_item.period_ms};
        w_el_sat    = w_el_sum[17] ? 17'h1FFFF : w_el_sum[16:0];

        if (i_item.kind == zclm_pkg::KIND_EDGE) begin
            // warm-up never restarts, so a dropped lock comes back on the next edge
            if (r_warmup > {1'b0, i_cfg.min_detect_cycles}) begin
                n_lock = 1'b1;
                n_led  = (r_led == 16'hFFFF) ? r_led : r_led + 16'd1;
            end else begin
                n_warmup = (r_warmup == 9'h1FF) ? r_warmup : r_warmup + 9'd1;
            end
            n_wec = (r_wec == 16'hFFFF) ? r_wec : r_wec + 16'd1;
        end else begin
            n_tick = w_tick_inc;
            if (r_lock && (r_led >= w_tick_inc)) begin
                n_led  = '0;
                n_tick = '0;
            end else if (w_tick_inc > r_led) begin
                // edges fell behind ticks: count a fault, drop lock past the limit
                n_led  = '0;
                n_tick = '0;
                if (w_fault_inc > zclm_pkg::FAULT_LIMIT) begin
                    n_fault = '0;
                    n_lock  = 1'b0;
                end else begin
                    n_fault = w_fault_inc;
                end
            end

            n_elapsed = w_el_sat;
            if (w_el_sat >= {1'b0, i_cfg.window_ms}) begin
                n_elapsed = '0;
                n_wec     = '0;
                if ((r_wec > i_cfg.band50_low) && (r_wec <= i_cfg.band50_high)) begin
                    n_freq = zclm_pkg::FREQ_A_HZ;
                end else if ((r_wec > i_cfg.band60_low) && (r_wec <= i_cfg.band60_high)) begin
                    n_freq = zclm_pkg::FREQ_B_HZ;
                end else begin
                    n_freq = zclm_pkg::FREQ_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup  <= '0;
            r_lock    <= 1'b0;
            r_led     <= '0;
            r_tick    <= '0;
            r_fault   <= '0;
            r_wec     <= '0;
            r_elapsed <= '0;
            r_freq    <= zclm_pkg::FREQ_NONE;
        end else if (i_valid) begin
            r_warmup  <= n_warmup;
            r_lock    <= n_lock;
            r_led     <= n_led;
            r_tick    <= n_tick;
            r_fault   <= n_fault;
            r_wec     <= n_wec;
            r_elapsed <= n_elapsed;
            r_freq    <= n_freq;
        end
    end

    assign o_result.locked  = n_lock;
    assign o_result.freq_hz = n_freq;

endmodule

// File: src/zero_cross_lock_and_mains_freq.sv
`timescale 1ns / 1ps

// Zero-cross lock monitor and mains frequency classifier. Each input transfer
// is an edge event (tuser = 0) or an update tick (tuser = 1) with the elapsed
// milliseconds in tdata; each one yields exactly one output transfer carrying
// the lock flag and the last classified frequency (0, 50 or 60 Hz) after that
// item is applied. Throughput is one item per clock: all counters update
// together from the input register, so an item enters every cycle while
// the output is taken. The input transfer loads the input register, which
// passes its item on to the result register once that register is free; a
// stalled output holds the input register and drops input ready until the
// result is taken. Configuration over APB takes effect at once and should
// be written only while no items are in flight; no clearing pass is needed
// after reset.
module zero_cross_lock_and_mains_freq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [15:0]                i_s_axis_tdata,  // [15:0] period_ms
    input  logic                       i_s_axis_tuser,  // [0] kind
    // output stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,  // [0] locked, [6:1] freq_hz, [7] zero
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [zclm_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    zclm_pkg::t_cfg    r_cfg;
    zclm_pkg::t_item   r_in_item;
    zclm_pkg::t_result w_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              w_out_free;
    logic              w_move;
    logic              w_cfg_wr;
    logic [2:0]        w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_detect_cycles <= zclm_pkg::RST_MIN_DETECT;
            r_cfg.window_ms         <= zclm_pkg::RST_WINDOW_MS;
            r_cfg.band50_low        <= zclm_pkg::RST_B50_LOW;
            r_cfg.band50_high       <= zclm_pkg::RST_B50_HIGH;
            r_cfg.band60_low        <= zclm_pkg::RST_B60_LOW;
            r_cfg.band60_high       <= zclm_pkg::RST_B60_HIGH;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                zclm_pkg::REG_MIN_DETECT: r_cfg.min_detect_cycles <= pwdata[7:0];
                zclm_pkg::REG_WINDOW_MS:  r_cfg.window_ms         <= pwdata[15:0];
                zclm_pkg::REG_B50_LOW:    r_cfg.band50_low        <= pwdata[15:0];
                zclm_pkg::REG_B50_HIGH:   r_cfg.band50_high       <= pwdata[15:0];
                zclm_pkg::REG_B60_LOW:    r_cfg.band60_low        <= pwdata[15:0];
                zclm_pkg::REG_B60_HIGH:   r_cfg.band60_high       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            zclm_pkg::REG_MIN_DETECT: prdata = {24'd0, r_cfg.min_detect_cycles};
            zclm_pkg::REG_WINDOW_MS:  prdata = {16'd0, r_cfg.window_ms};
            zclm_pkg::REG_B50_LOW:    prdata = {16'd0, r_cfg.band50_low};
            zclm_pkg::REG_B50_HIGH:   prdata = {16'd0, r_cfg.band50_high};
            zclm_pkg::REG_B60_LOW:    prdata = {16'd0, r_cfg.band60_low};
            zclm_pkg::REG_B60_HIGH:   prdata = {16'd0, r_cfg.band60_high};
            default:                  prdata = 32'd0;
        endcase
    end

    // advance the input register whenever the result register can take its item
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_move          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_item.kind      <= i_s_axis_tuser;
            r_in_item.period_ms <= i_s_axis_tdata;
        end
    end

    zclm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_move),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_data <= {1'b0, w_result.freq_hz, w_result.locked};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: src/zclm_checker.sv
`timescale 1ns / 1ps
`include "zero_cross_lock_and_mains_freq_macros.svh"

module zclm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       psel,
    input logic       pready
);

    logic w_out_stall;
    logic w_in_xfer;
    logic w_freq_ok;

    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_freq_ok   = (o_m_axis_tdata[6:1] == zclm_pkg::FREQ_NONE ||
                          o_m_axis_tdata[6:1] == zclm_pkg::FREQ_A_HZ ||
                          o_m_axis_tdata[6:1] == zclm_pkg::FREQ_B_HZ) && !o_m_axis_tdata[7];

    // a stalled result holds
    `ZCLM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // an empty result register never back-pressures the input
    `ZCLM_ASSERT_SAME(a_in_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    // only the three known frequencies are reported, pad bit stays clear
    `ZCLM_ASSERT_SAME(a_freq_code, i_clk, i_rst_n, o_m_axis_tvalid, w_freq_ok)
    // an accepted item reaches the output once the result side is ready in the cycle after the transfer
    `ZCLM_ASSERT_SEQ(a_latency, i_clk, i_rst_n, w_in_xfer, i_m_axis_tready, o_m_axis_tvalid)
    // the configuration port never waits
    `ZCLM_ASSERT_SAME(a_pready, i_clk, i_rst_n, psel, pready)

endmodule

bind zero_cross_lock_and_mains_freq zclm_checker u_zclm_checker (.*);
